/* rtl/core/xild_pkg.sv */
// ----------------------------------------------------------------------------
// xild_pkg: shared types, constants and opcode tables
// Payload structs, decode phase codes, immediate classes and opcode maps
// for the x86 instruction length decoder.
// ----------------------------------------------------------------------------
package xild_pkg;

   localparam int unsigned MAX_LENGTH = 15;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [4:0]         length;
      logic [5:0]         prefix_flags;
      logic [7:0]         segment_byte;
      logic [2:0]         opcode_map;
      logic [7:0]         opcode_byte;
      logic [8:0]         modrm_field;
      logic [8:0]         sib_field;
      logic [2:0]         disp_bytes;
      logic signed [31:0] displacement;
      logic [2:0]         imm_bytes_count;
      logic signed [31:0] immediate;
   } rsp_type;

   // status codes
   localparam logic [1:0] ST_DECODED   = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_TOO_LONG  = 2'd2;

   // decode phases
   localparam logic [2:0] PH_PREFIX = 3'd0;
   localparam logic [2:0] PH_ESC    = 3'd1;
   localparam logic [2:0] PH_ESC3   = 3'd2;
   localparam logic [2:0] PH_MODRM  = 3'd3;
   localparam logic [2:0] PH_SIB    = 3'd4;
   localparam logic [2:0] PH_DISP   = 3'd5;
   localparam logic [2:0] PH_IMM    = 3'd6;

   // opcode maps
   localparam logic [2:0] MAP_ONE  = 3'd1;
   localparam logic [2:0] MAP_0F   = 3'd2;
   localparam logic [2:0] MAP_0F38 = 3'd3;
   localparam logic [2:0] MAP_0F3A = 3'd4;

   // immediate classes
   localparam logic [3:0] C_NONE  = 4'd0;
   localparam logic [3:0] C_B     = 4'd1;
   localparam logic [3:0] C_W     = 4'd2;
   localparam logic [3:0] C_D     = 4'd3;
   localparam logic [3:0] C_Z     = 4'd4;
   localparam logic [3:0] C_P     = 4'd5;
   localparam logic [3:0] C_MOFFS = 4'd6;
   localparam logic [3:0] C_ENTER = 4'd7;
   localparam logic [3:0] C_GRP3  = 4'd8;

   localparam logic [7:0] MODRM_FOLLOWS = 8'h80;
   localparam logic [7:0] OP_ESC    = 8'h0F;
   localparam logic [7:0] OP_ESC38  = 8'h38;
   localparam logic [7:0] OP_ESC3A  = 8'h3A;
   localparam logic [7:0] OP_OPSIZE = 8'h66;
   localparam logic [7:0] OP_ADSIZE = 8'h67;
   localparam logic [7:0] OP_GRP3B  = 8'hF6;

   localparam logic [7:0] MAP_ONE_TABLE [256] = '{
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h04,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h80,8'h80,8'h00,8'h00,8'h00,8'h00,
      8'h04,8'h84,8'h01,8'h81,8'h00,8'h00,8'h00,8'h00,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
      8'h81,8'h84,8'h81,8'h81,8'h80,8'h80,8'h80,8'h80,
      8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h05,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h06,8'h06,8'h06,8'h06,8'h00,8'h00,8'h00,8'h00,
      8'h01,8'h04,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
      8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,8'h04,
      8'h81,8'h81,8'h02,8'h00,8'h80,8'h80,8'h81,8'h84,
      8'h07,8'h00,8'h02,8'h00,8'h00,8'h01,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h01,8'h01,8'h00,8'h00,
      8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,
      8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,
      8'h04,8'h04,8'h05,8'h01,8'h00,8'h00,8'h00,8'h00,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h88,8'h88,
      8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h80,8'h80
   };

   // two-byte (0F) map entry: ModRM flag in bit 7, immediate class below
   function automatic logic [7:0] map_two(input logic [7:0] op);
      logic none_c;
      logic b_c;
      none_c = (op >= 8'h05 && op <= 8'h09) || op == 8'h0B || op == 8'h0E ||
               op == 8'hFF || (op >= 8'h30 && op <= 8'h35) || op == 8'hA0 ||
               op == 8'hA1 || op == 8'hA2 || op == 8'hA8 || op == 8'hA9 ||
               op == 8'hAA || (op >= 8'hC8 && op <= 8'hCF);
      b_c = (op >= 8'h70 && op <= 8'h73) || op == 8'hA4 || op == 8'hAC ||
            op == 8'hBA || op == 8'hC2 || (op >= 8'hC4 && op <= 8'hC6);
      if (none_c)
         return {4'h0, C_NONE};
      else if (op >= 8'h80 && op <= 8'h8F)
         return {4'h0, C_Z};
      else if (b_c)
         return MODRM_FOLLOWS | {4'h0, C_B};
      else
         return MODRM_FOLLOWS;
   endfunction

   // sign- or zero-fit a gathered value to its byte count
   function automatic logic [31:0] sign_fit(input logic [31:0] v, input logic [2:0] size);
      unique case (size)
         3'd1:    return {{24{v[7]}}, v[7:0]};
         3'd2:    return {{16{v[15]}}, v[15:0]};
         3'd3:    return {8'h00, v[23:0]};
         3'd4:    return v;
         default: return 32'h0;
      endcase
   endfunction

endpackage

/* rtl/core/x86_instruction_length_decoder_top.sv */
// ----------------------------------------------------------------------------
// x86_instruction_length_decoder_top
// Splits a 32-bit x86 code byte stream into instructions.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one code byte per beat, with end_of_buffer on the last
//   available byte. rsp channel: one beat per finished instruction, or a
//   truncated beat when end_of_buffer arrives mid-instruction.
//   Each byte is decoded by a table lookup and small updates in the cycle
//   it is accepted; a result is written to the output register when the
//   byte that completes it is accepted. Throughput is one byte per cycle unless stalled.
//   req_ready drops while the output register holds a result that the
//   receiver has not yet taken; the output register refills in the same
//   cycle it drains.
//   Reset puts the decoder in the prefix phase with all held fields zero
//   and empties the output register. After an end_of_buffer byte the
//   decoder starts over.
// ----------------------------------------------------------------------------
module x86_instruction_length_decoder_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xild_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xild_pkg::rsp_type rsp_data
);
   import xild_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [5:0]  pfx_ff, pfx_in;
   logic [7:0]  seg_ff, seg_in;
   logic [2:0]  map_ff, map_in;
   logic [7:0]  opc_ff, opc_in;
   logic [3:0]  icls_ff, icls_in;
   logic [8:0]  modrm_ff, modrm_in;
   logic [8:0]  sib_ff, sib_in;
   logic [31:0] disp_ff, disp_in;
   logic [2:0]  dsz_ff, dsz_in;
   logic [31:0] imm_ff, imm_in;
   logic [2:0]  isz_ff, isz_in;
   logic [2:0]  left_ff, left_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        out_valid_ff;
   rsp_type     out_ff, out_in;

   logic       accept, done, emit;
   logic [7:0] b;
   logic [4:0] cnt;
   logic [7:0] entry;
   logic       do_op, do_disp, do_imm;
   logic [2:0] dsize, isize;
   logic [1:0] mod_b;
   logic [2:0] rm_b, dpos, ipos;
   logic       op16, ad16;

   assign req_ready = !out_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.code_byte;
   assign cnt       = (cnt_ff < 5'd16) ? cnt_ff + 5'd1 : cnt_ff;
   assign mod_b     = b[7:6];
   assign rm_b      = b[2:0];

   // decode one byte: phase step, then opcode/disp/imm starts chain in order
   always_comb begin
      phase_in = phase_ff; pfx_in = pfx_ff; seg_in = seg_ff; map_in = map_ff;
      opc_in = opc_ff; icls_in = icls_ff; modrm_in = modrm_ff; sib_in = sib_ff;
      disp_in = disp_ff; dsz_in = dsz_ff; imm_in = imm_ff; isz_in = isz_ff;
      left_in = left_ff;
      done = 1'b0; do_op = 1'b0; do_disp = 1'b0; do_imm = 1'b0;
      entry = 8'h00; dsize = 3'd0; isize = 3'd0;
      dpos = 3'd0; ipos = 3'd0;
      op16 = 1'b0; ad16 = 1'b0;
      unique case (phase_ff)
         PH_ESC: begin
            if (b == OP_ESC38 || b == OP_ESC3A) begin
               map_in = (b == OP_ESC38) ? MAP_0F38 : MAP_0F3A;
               phase_in = PH_ESC3;
            end else begin
               opc_in = b; entry = map_two(b); do_op = 1'b1;
            end
         end
         PH_ESC3: begin
            opc_in = b; do_op = 1'b1;
            entry = MODRM_FOLLOWS |
                    ((map_ff == MAP_0F3A) ? {4'h0, C_B} : {4'h0, C_NONE});
         end
         PH_MODRM: begin
            modrm_in = {1'b1, b};
            do_disp = 1'b1;
            if (mod_b != 2'd3) begin
               if (pfx_ff[4]) begin
                  if (mod_b == 2'd1) dsize = 3'd1;
                  else if (mod_b == 2'd2 || rm_b == 3'd6) dsize = 3'd2;
               end else if (rm_b == 3'd4) begin
                  phase_in = PH_SIB; do_disp = 1'b0;
               end else begin
                  if (mod_b == 2'd1) dsize = 3'd1;
                  else if (mod_b == 2'd2 || rm_b == 3'd5) dsize = 3'd4;
               end
            end
         end
         PH_SIB: begin
            sib_in = {1'b1, b};
            do_disp = 1'b1;
            if (modrm_ff[7:6] == 2'd1) dsize = 3'd1;
            else if (modrm_ff[7:6] == 2'd2 || b[2:0] == 3'd5) dsize = 3'd4;
         end
         PH_DISP: begin
            dpos = dsz_ff - left_ff;
            unique case (dpos[1:0])
               2'd0: disp_in[7:0]   = disp_ff[7:0]   | b;
               2'd1: disp_in[15:8]  = disp_ff[15:8]  | b;
               2'd2: disp_in[23:16] = disp_ff[23:16] | b;
               2'd3: disp_in[31:24] = disp_ff[31:24] | b;
               default: ;
            endcase
            left_in = left_ff - 3'd1;
            if (left_ff == 3'd1) do_imm = 1'b1;
         end
         PH_IMM: begin
            ipos = isz_ff - left_ff;
            priority case (ipos)
               3'd0: imm_in[7:0]   = imm_ff[7:0]   | b;
               3'd1: imm_in[15:8]  = imm_ff[15:8]  | b;
               3'd2: imm_in[23:16] = imm_ff[23:16] | b;
               3'd3: imm_in[31:24] = imm_ff[31:24] | b;
               default: ;
            endcase
            left_in = left_ff - 3'd1;
            if (left_ff == 3'd1) done = 1'b1;
         end
         default: begin
            priority if (b == 8'hF0) pfx_in[0] = 1'b1;
            else if (b == 8'hF2) pfx_in[1] = 1'b1;
            else if (b == 8'hF3) pfx_in[2] = 1'b1;
            else if (b == OP_OPSIZE) pfx_in[3] = 1'b1;
            else if (b == OP_ADSIZE) pfx_in[4] = 1'b1;
            else if (b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h26 ||
                     b == 8'h64 || b == 8'h65) begin
               pfx_in[5] = 1'b1; seg_in = b;
            end else if (b == OP_ESC) begin
               map_in = MAP_0F; phase_in = PH_ESC;
            end else begin
               map_in = MAP_ONE; opc_in = b;
               entry = MAP_ONE_TABLE[b]; do_op = 1'b1;
            end
         end
      endcase

      // opcode seen: go to ModRM or straight to the immediate
      if (do_op) begin
         icls_in = entry[3:0];
         if (entry[7]) phase_in = PH_MODRM;
         else do_imm = 1'b1;
      end
      // start displacement
      if (do_disp) begin
         dsz_in = dsize; disp_in = 32'h0;
         if (dsize == 3'd0) do_imm = 1'b1;
         else begin
            left_in = dsize; phase_in = PH_DISP;
         end
      end
      // start immediate, sized from class, prefixes and group-3 reg
      if (do_imm) begin
         op16 = pfx_in[3];
         ad16 = pfx_in[4];
         unique case (icls_in)
            C_B:     isize = 3'd1;
            C_W:     isize = 3'd2;
            C_D:     isize = 3'd4;
            C_Z:     isize = op16 ? 3'd2 : 3'd4;
            C_P:     isize = op16 ? 3'd4 : 3'd6;
            C_MOFFS: isize = ad16 ? 3'd2 : 3'd4;
            C_ENTER: isize = 3'd3;
            C_GRP3: begin
               if (modrm_in[5:3] > 3'd1) isize = 3'd0;
               else if (opc_in == OP_GRP3B) isize = 3'd1;
               else isize = op16 ? 3'd2 : 3'd4;
            end
            default: isize = 3'd0;
         endcase
         isz_in = isize; imm_in = 32'h0;
         if (isize == 3'd0) done = 1'b1;
         else begin
            left_in = isize; phase_in = PH_IMM;
         end
      end
   end

   assign emit = done || req_data.end_of_buffer;

   // build the result beat
   always_comb begin
      out_in = '0;
      out_in.length = cnt;
      if (done) begin
         out_in.status          = (cnt > 5'(MAX_LENGTH)) ? ST_TOO_LONG : ST_DECODED;
         out_in.prefix_flags    = pfx_in;
         out_in.segment_byte    = seg_in;
         out_in.opcode_map      = map_in;
         out_in.opcode_byte     = opc_in;
         out_in.modrm_field     = modrm_in;
         out_in.sib_field       = sib_in;
         out_in.disp_bytes      = dsz_in;
         out_in.displacement    = sign_fit(disp_in, dsz_in);
         out_in.imm_bytes_count = isz_in;
         out_in.immediate       = sign_fit(imm_in, isz_in);
      end else begin
         out_in.status = ST_TRUNCATED;
      end
   end

   // advance decode state; start over after each result
   always_ff @(posedge clock) begin
      if (reset || (accept && emit)) begin
         phase_ff <= PH_PREFIX; pfx_ff <= '0; seg_ff <= '0; map_ff <= '0;
         opc_ff <= '0; icls_ff <= '0; modrm_ff <= '0; sib_ff <= '0;
         disp_ff <= '0; dsz_ff <= '0; imm_ff <= '0; isz_ff <= '0;
         left_ff <= '0; cnt_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in; pfx_ff <= pfx_in; seg_ff <= seg_in; map_ff <= map_in;
         opc_ff <= opc_in; icls_ff <= icls_in; modrm_ff <= modrm_in; sib_ff <= sib_in;
         disp_ff <= disp_in; dsz_ff <= dsz_in; imm_ff <= imm_in; isz_ff <= isz_in;
         left_ff <= left_in; cnt_ff <= cnt;
      end
   end

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (accept && emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
